FILE: design/gds_pkg.sv
// Shared types and constants of the grid diffusion stencil block.
package gds_pkg;

    localparam int GRID_MAX  = 256;
    localparam int ADDR_W    = $clog2(GRID_MAX);
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int VAL_W     = 24;
    localparam int GAIN_W    = 16;
    localparam int GSIZE_W   = 9;
    localparam int IDX_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = VAL_W + 3;
    localparam int PROD_W    = SUM_W + GAIN_W + 1;
    localparam int FRAC_W    = 16;
    localparam int RES_W     = PROD_W - FRAC_W + 1;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY  = 2'd2;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [2:0]              t_jobs;

    // One bit per stencil evaluation that an input word can release.
    localparam t_jobs JOB_MAIN = 3'b001;
    localparam t_jobs JOB_LEFT = 3'b010;
    localparam t_jobs JOB_FIN  = 3'b100;

    typedef struct packed {
        logic [SIZE_W-1:0] n;
        logic [GAIN_W-1:0] gain;
        t_val              bound;
    } t_cfg;

    typedef struct packed {
        t_val              x;
        t_val              centre;
        t_val              up;
        t_val              left;
        t_val              right;
        t_val              prevc;
        t_val              left2;
        t_val              p1;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        t_jobs             jobs;
    } t_q_entry;

endpackage

FILE: design/gds_front.sv
// Front end: position counters, the two line stores and operand gathering per word.
module gds_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gds_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  gds_pkg::t_val     i_cell,
    output logic              o_push,
    input  logic              i_push_ready,
    output gds_pkg::t_q_entry o_entry
);
    import gds_pkg::*;

    logic [ADDR_W-1:0] r_row, r_col, n_row, n_col;
    logic [ADDR_W-1:0] a_row, a_col, a_col_nx;
    logic              a_wrap, a_last_row, a_last_col, accept;

    t_val r_recent [GRID_MAX];
    t_val r_older  [GRID_MAX];
    t_val r_rd_centre, r_rd_right, r_rd_up;
    t_val r_p1, r_p2, r_prevc;

    logic              r_b_valid;
    t_val              r_b_x, r_b_p1, r_b_p2;
    logic [ADDR_W-1:0] r_b_row, r_b_col;
    logic              r_b_main, r_b_lrow, r_b_c0, r_b_c1, r_b_cend, r_b_r1;
    logic              b_adv;
    t_jobs             b_jobs;

    // Counters left beyond a lowered grid size restart the grid.
    always_comb begin
        a_wrap     = ({1'b0, r_row} >= i_cfg.n) || ({1'b0, r_col} >= i_cfg.n);
        a_row      = a_wrap ? '0 : r_row;
        a_col      = a_wrap ? '0 : r_col;
        a_col_nx   = a_col + ADDR_W'(1);
        a_last_row = ({1'b0, a_row} == i_cfg.n - SIZE_W'(1));
        a_last_col = ({1'b0, a_col} == i_cfg.n - SIZE_W'(1));
        if (a_last_col) begin
            n_col = '0;
            n_row = a_last_row ? '0 : a_row + ADDR_W'(1);
        end else begin
            n_col = a_col + ADDR_W'(1);
            n_row = a_row;
        end
    end

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_b_valid || b_adv;

    always_comb begin
        b_jobs = '0;
        if (r_b_main) begin
            b_jobs = b_jobs | JOB_MAIN;
        end
        if (r_b_lrow && !r_b_c0) begin
            b_jobs = b_jobs | JOB_LEFT;
        end
        if (r_b_lrow && r_b_cend) begin
            b_jobs = b_jobs | JOB_FIN;
        end
        o_entry.x      = r_b_x;
        o_entry.centre = r_rd_centre;
        o_entry.up     = r_b_r1 ? i_cfg.bound : r_rd_up;
        o_entry.left   = r_b_c0 ? i_cfg.bound : r_prevc;
        o_entry.right  = r_b_cend ? i_cfg.bound : r_rd_right;
        o_entry.prevc  = r_prevc;
        o_entry.left2  = r_b_c1 ? i_cfg.bound : r_b_p2;
        o_entry.p1     = r_b_p1;
        o_entry.row    = r_b_row;
        o_entry.col    = r_b_col;
        o_entry.jobs   = b_jobs;
    end

    // Words of the first row release nothing and leave without a queue slot.
    assign o_push = r_b_valid && (b_jobs != '0);
    assign b_adv  = r_b_valid && ((b_jobs == '0) || i_push_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (o_ready) begin
                r_b_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_x    <= i_cell;
            r_b_row  <= a_row;
            r_b_col  <= a_col;
            r_b_main <= (a_row != '0);
            r_b_lrow <= a_last_row;
            r_b_cend <= a_last_col;
            r_b_c0   <= (a_col == '0);
            r_b_c1   <= (a_col == ADDR_W'(1));
            r_b_r1   <= (a_row == ADDR_W'(1));
            r_b_p1   <= r_p1;
            r_b_p2   <= r_p2;
            r_p1     <= i_cell;
            r_p2     <= r_p1;
        end
        if (b_adv) begin
            r_prevc <= r_rd_centre;
        end
    end

    // The recent row store is read before it is overwritten at the same column.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_recent[a_col] <= i_cell;
            r_rd_centre     <= r_recent[a_col];
            r_rd_right      <= r_recent[a_col_nx];
        end
    end

    // The older row store takes the displaced value one stage later.
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_older[r_b_col] <= r_rd_centre;
        end
        if (accept) begin
            r_rd_up <= r_older[a_col];
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (({1'b0, r_col} < $past(i_cfg.n)) && ({1'b0, r_row} < $past(i_cfg.n))))
        else $error("position counter left the grid after a word");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_adv) |=> (r_b_valid && $stable(r_b_col) && $stable(r_rd_centre)))
        else $error("held word in the gather stage changed");

endmodule

FILE: design/gds_queue.sv
// Short queue of gathered stencil operands between the front and back ends.
module gds_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_push_ready,
    input  gds_pkg::t_q_entry i_entry,
    output logic              o_valid,
    input  logic              i_pop,
    output gds_pkg::t_q_entry o_entry
);
    import gds_pkg::*;

    t_q_entry        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            push_fire;

    assign o_push_ready = (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_entry      = r_mem[r_rp];
    assign push_fire    = i_push && o_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_fire) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({push_fire, i_pop})
                2'b10: begin
                    r_cnt <= r_cnt + (Q_AW + 1)'(1);
                end
                2'b01: begin
                    r_cnt <= r_cnt - (Q_AW + 1)'(1);
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= (Q_AW + 1)'(Q_DEPTH)) && (!i_pop || o_valid))
        else $error("queue overflow or pop from an empty queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_fire && !i_pop) |=> (r_cnt == $past(r_cnt) + (Q_AW + 1)'(1)))
        else $error("queue fill count lost a push");

endmodule

FILE: design/gds_back.sv
// Back end: walks the stencil jobs of each queued word through sum, gain and saturation.
module gds_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gds_pkg::t_cfg                 i_cfg,
    input  logic                          i_q_valid,
    input  gds_pkg::t_q_entry             i_q_entry,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output gds_pkg::t_val                 o_new_value,
    output logic [gds_pkg::IDX_W-1:0]     o_out_row,
    output logic [gds_pkg::IDX_W-1:0]     o_out_col,
    output logic                          o_last
);
    import gds_pkg::*;

    localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'((2 ** (VAL_W - 1)) - 1);
    localparam logic signed [RES_W-1:0] SAT_MIN = RES_W'(-(2 ** (VAL_W - 1)));

    function automatic logic [IDX_W-1:0] idx8(logic [ADDR_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[IDX_W-1:0];
    endfunction

    t_jobs             r_done, pending, sel;
    logic              job_last, issue, rdy1, rdy2, rdy3;
    t_val              j_up, j_left, j_right, j_down, j_centre;
    logic [ADDR_W-1:0] j_row, j_col;

    logic                     r_v1, r_v2, r_v3;
    logic signed [SUM_W-1:0]  sum, r1_sum;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod, r2_prod;
    logic signed [RES_W-1:0]  res;
    t_val                     sat, r1_centre, r2_centre;
    logic [ADDR_W-1:0]        r1_row, r1_col, r2_row, r2_col;
    logic                     r1_last, r2_last;

    t_val             r_o_value;
    logic [IDX_W-1:0] r_o_row, r_o_col;
    logic             r_o_last;

    // The lowest pending job of the head word goes next.
    always_comb begin
        pending  = i_q_valid ? (i_q_entry.jobs & ~r_done) : '0;
        sel      = pending & (~pending + t_jobs'(1));
        job_last = ((pending & ~sel) == '0);
        rdy3     = !r_v3 || i_ready;
        rdy2     = !r_v2 || rdy3;
        rdy1     = !r_v1 || rdy2;
        issue    = i_q_valid && rdy1;
        o_q_pop  = issue && job_last;
    end

    always_comb begin
        case (sel)
            JOB_MAIN: begin
                j_up     = i_q_entry.up;
                j_left   = i_q_entry.left;
                j_right  = i_q_entry.right;
                j_down   = i_q_entry.x;
                j_centre = i_q_entry.centre;
                j_row    = i_q_entry.row - ADDR_W'(1);
                j_col    = i_q_entry.col;
            end
            JOB_LEFT: begin
                j_up     = i_q_entry.prevc;
                j_left   = i_q_entry.left2;
                j_right  = i_q_entry.x;
                j_down   = i_cfg.bound;
                j_centre = i_q_entry.p1;
                j_row    = i_q_entry.row;
                j_col    = i_q_entry.col - ADDR_W'(1);
            end
            JOB_FIN: begin
                j_up     = i_q_entry.centre;
                j_left   = i_q_entry.p1;
                j_right  = i_cfg.bound;
                j_down   = i_cfg.bound;
                j_centre = i_q_entry.x;
                j_row    = i_q_entry.row;
                j_col    = i_q_entry.col;
            end
            default: begin
                j_up     = '0;
                j_left   = '0;
                j_right  = '0;
                j_down   = '0;
                j_centre = '0;
                j_row    = '0;
                j_col    = '0;
            end
        endcase
    end

    // Arithmetic shift of the product rounds toward minus infinity.
    always_comb begin
        sum    = SUM_W'(j_up) + SUM_W'(j_left) + SUM_W'(j_right) + SUM_W'(j_down)
                 - (SUM_W'(j_centre) <<< 2);
        gain_s = $signed({1'b0, i_cfg.gain});
        prod   = r1_sum * gain_s;
        res    = RES_W'(r2_centre) + RES_W'($signed(r2_prod[PROD_W-1:FRAC_W]));
        if (res > SAT_MAX) begin
            sat = SAT_MAX[VAL_W-1:0];
        end else if (res < SAT_MIN) begin
            sat = SAT_MIN[VAL_W-1:0];
        end else begin
            sat = res[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= '0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_q_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (issue) begin
                r_done <= job_last ? '0 : (r_done | sel);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r1_sum    <= sum;
            r1_centre <= j_centre;
            r1_row    <= j_row;
            r1_col    <= j_col;
            r1_last   <= job_last;
        end
        if (rdy2 && r_v1) begin
            r2_prod   <= prod;
            r2_centre <= r1_centre;
            r2_row    <= r1_row;
            r2_col    <= r1_col;
            r2_last   <= r1_last;
        end
        if (rdy3 && r_v2) begin
            r_o_value <= sat;
            r_o_row   <= idx8(r2_row);
            r_o_col   <= idx8(r2_col);
            r_o_last  <= r2_last;
        end
    end

    assign o_valid     = r_v3;
    assign o_new_value = r_o_value;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_last      = r_o_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (pending != '0))
        else $error("queued word has no job left to run");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_done == '0))
        else $error("job record not cleared after the word left the queue");

endmodule

FILE: design/grid_diffusion_stencil_step_top.sv
// Top level of the five-point diffusion stencil step with its configuration registers.
//
// Input channel: one grid cell word per handshake on i_in_valid / o_in_ready, row-major.
// Output channel: updated cell words on o_out_valid / i_out_ready with row, column and
// a flag on the last word released by one input word. Cell (r, c) is released by the
// input word at (r + 1, c); in the last row, cell (r, c) is released at (r, c + 1),
// the last cell by itself; words pass the gather stage, queue and three back stages.
// Throughput: one input word per cycle up to the last row; there each word but the
// first releases two results (three at the last cell), and the single output register
// then paces the input at one result per cycle through the 4-entry operand queue.
// Each line store has one write port, and the recent row store two read ports.
// Reset: position counters go to zero and the registers to grid size 16, gain 6554
// and boundary 1.0; line stores are not cleared, the first row of a grid fills them.
// Receiver stall: the three back stages hold, the queue fills and o_in_ready drops.
// Configuration: o_cfg_ready is always high; write only while no word is in flight.
module grid_diffusion_stencil_step_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  gds_pkg::t_val                    i_cell_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output gds_pkg::t_val                    o_new_value,
    output logic [gds_pkg::IDX_W-1:0]        o_out_row,
    output logic [gds_pkg::IDX_W-1:0]        o_out_col,
    output logic                             o_last_in_run,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gds_pkg::VAL_W-1:0]        i_cfg_data
);
    import gds_pkg::*;

    localparam logic [GSIZE_W-1:0] GSIZE_RST = 9'd16;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd6554;
    localparam t_val               BOUND_RST = 24'sd1048576;
    localparam int                 MIN_SIZE  = 3;

    function automatic logic [SIZE_W-1:0] clamp_size(logic [GSIZE_W-1:0] gs);
        int unsigned v;
        v = 32'(gs);
        if (v < MIN_SIZE) begin
            v = MIN_SIZE;
        end
        if (v > GRID_MAX) begin
            v = GRID_MAX;
        end
        return SIZE_W'(v);
    endfunction

    logic [GSIZE_W-1:0] r_grid_size;
    logic [GAIN_W-1:0]  r_step_gain;
    t_val               r_boundary;
    t_cfg               cfg;

    logic     q_push, q_push_ready, q_valid, q_pop;
    t_q_entry q_entry_in, q_entry_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GSIZE_RST;
            r_step_gain <= GAIN_RST;
            r_boundary  <= BOUND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_SIZE: begin
                    r_grid_size <= i_cfg_data[GSIZE_W-1:0];
                end
                CFG_STEP_GAIN: begin
                    r_step_gain <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_BOUNDARY: begin
                    r_boundary <= i_cfg_data;
                end
                default: begin
                    r_grid_size <= r_grid_size;
                end
            endcase
        end
    end

    always_comb begin
        cfg.n     = clamp_size(r_grid_size);
        cfg.gain  = r_step_gain;
        cfg.bound = r_boundary;
    end

    gds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_cell       (i_cell_value),
        .o_push       (q_push),
        .i_push_ready (q_push_ready),
        .o_entry      (q_entry_in)
    );

    gds_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .o_push_ready (q_push_ready),
        .i_entry      (q_entry_in),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_entry      (q_entry_out)
    );

    gds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry_out),
        .o_q_pop     (q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_new_value (o_new_value),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last_in_run)
    );

endmodule

FILE: test/tb.sv
// Self-checking testbench for the five-point diffusion stencil step block.
`timescale 1ns / 100ps

module tb;
    import gds_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;

    localparam t_val VAL_HI        = 24'sh7FFFFF;
    localparam t_val VAL_LO        = 24'sh800000;
    localparam t_val ONE_VOLT      = 24'sh100000;
    localparam int   SETTLE_CYCLES = 10;
    localparam int   CYCLE_LIMIT   = 300000;
    localparam int   MAX_REPORTS   = 100;

    typedef struct {
        t_val             value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_cell_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    t_val                 i_cell_value  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    t_val                 o_new_value;
    logic [IDX_W-1:0]     o_out_row;
    logic [IDX_W-1:0]     o_out_col;
    logic                 o_last_in_run;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [VAL_W-1:0]     i_cfg_data    = '0;

    // Predictor state: the two line stores, position, last cell and registers.
    t_val               older_row [GRID_MAX];
    t_val               recent_row [GRID_MAX];
    int                 row_pos;
    int                 col_pos;
    t_val               prev_cell;
    logic [GSIZE_W-1:0] grid_size_q;
    logic [GAIN_W-1:0]  gain_q;
    t_val               bound_q;

    t_cell_result pending_cells [$];
    int           fail_count      = 0;
    int           cycle_count     = 0;
    int           sender_idle_pct = 12;
    int           recv_idle_pct   = 68;

    grid_diffusion_stencil_step_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cell_value  (i_cell_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_new_value   (o_new_value),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_in_run (o_last_in_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Old value plus the scaled Laplacian, floored by the shift, then clamped.
    function automatic t_val diffuse(input t_val up, input t_val left, input t_val right,
                                     input t_val down, input t_val centre);
        longint acc;
        longint res;
        acc = longint'(up) + longint'(left) + longint'(right) + longint'(down)
              - 4 * longint'(centre);
        res = longint'(centre) + ((acc * longint'(gain_q)) >>> FRAC_W);
        if (res > longint'(VAL_HI))
            res = longint'(VAL_HI);
        if (res < longint'(VAL_LO))
            res = longint'(VAL_LO);
        return t_val'(res);
    endfunction

    function automatic void queue_cell(input t_val value, input int r, input int c);
        t_cell_result item;
        item.value = value;
        item.row   = r[IDX_W-1:0];
        item.col   = c[IDX_W-1:0];
        item.last  = 1'b0;
        pending_cells.push_back(item);
    endfunction

    function automatic void predict_cell(input t_val x);
        int   n;
        int   r;
        int   c;
        int   k;
        t_val b;
        t_val up;
        t_val left;
        t_val right;
        n = int'(grid_size_q);
        if (n < 3)
            n = 3;
        if (n > GRID_MAX)
            n = GRID_MAX;
        // A shrunken grid that leaves the position outside restarts at the origin.
        if (row_pos >= n || col_pos >= n) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        b = bound_q;
        k = 0;
        if (r >= 1) begin
            up    = (r == 1) ? b : older_row[c];
            left  = (c == 0) ? b : older_row[c-1];
            right = (c == n - 1) ? b : recent_row[c+1];
            queue_cell(diffuse(up, left, right, x, recent_row[c]), r - 1, c);
            k++;
        end
        older_row[c]  = recent_row[c];
        recent_row[c] = x;
        // The bottom row has no row below, so it is released by its own words.
        if (r == n - 1) begin
            if (c >= 1) begin
                left = (c == 1) ? b : recent_row[c-2];
                queue_cell(diffuse(older_row[c-1], left, x, b, prev_cell), r, c - 1);
                k++;
            end
            if (c == n - 1) begin
                queue_cell(diffuse(older_row[c], recent_row[c-1], b, b, x), r, c);
                k++;
            end
        end
        if (k > 0)
            pending_cells[$].last = 1'b1;
        prev_cell = x;
        if (c + 1 >= n) begin
            col_pos = 0;
            row_pos = (r + 1 >= n) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_cell_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_cells.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, got %h row %0d col %0d",
                             $time, o_new_value, o_out_row, o_out_col);
            end else begin
                want = pending_cells.pop_front();
                report_field("new_value", 32'(want.value), 32'(o_new_value));
                report_field("out_row", 32'(want.row), 32'(o_out_row));
                report_field("out_col", 32'(want.col), 32'(o_out_col));
                report_field("last_in_run", 32'(want.last), 32'(o_last_in_run));
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with valid possibly still high.
    task automatic send_cell(input t_val x);
        i_in_valid   <= 1'b1;
        i_cell_value <= x;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_cell(x);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(negedge i_clk);
        // Words of a top row release nothing and may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Leaves the write channel valid so that back-to-back writes need no gap.
    task automatic config_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_GRID_SIZE: grid_size_q = data[GSIZE_W-1:0];
            CFG_STEP_GAIN: gain_q = data[GAIN_W-1:0];
            CFG_BOUNDARY:  bound_q = t_val'(data);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_config(input int size, input int gain, input t_val bound);
        logic [VAL_W-1:0] d;
        // Unused upper bits carry random noise; the block must ignore them.
        d = 24'($urandom);
        d[GSIZE_W-1:0] = size[GSIZE_W-1:0];
        config_write(CFG_GRID_SIZE, d);
        d = 24'($urandom);
        d[GAIN_W-1:0] = gain[GAIN_W-1:0];
        config_write(CFG_STEP_GAIN, d);
        config_write(CFG_BOUNDARY, bound);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_val pick_cell(input int mode, input t_val base);
        case (mode)
            0: return t_val'($urandom);
            1: return base + t_val'(int'($urandom_range(8191)) - 4096);
            default: begin
                case ($urandom_range(4))
                    0: return VAL_HI;
                    1: return VAL_LO;
                    2: return '0;
                    3: return '1;
                    default: return t_val'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic t_val pick_base();
        return t_val'(int'($urandom_range(1 << 22)) - (1 << 21));
    endfunction

    // Registers and position counters as they come out of reset.
    task automatic test_reset_values();
        logic [VAL_W-1:0] d;
        repeat (2 * 16 + 2) send_cell(pick_cell(1, ONE_VOLT));
        drain_results();
        // Shrinking to 3 leaves the position inside, so the grid finishes at once.
        d = 24'($urandom);
        d[GSIZE_W-1:0] = 9'd3;
        config_write(CFG_GRID_SIZE, d);
        i_cfg_valid <= 1'b0;
        send_cell(pick_cell(1, ONE_VOLT));
    endtask

    // Sizes below the minimum act as 3; extreme cells with full and zero gain.
    task automatic test_small_grid_extremes();
        t_val corner [9];
        corner = '{VAL_HI, VAL_LO, '0, '1, VAL_HI, VAL_LO, 24'sd1, VAL_LO, VAL_HI};
        drain_results();
        config_write(REG_SPARE, 24'($urandom));
        write_config(2, 65535, VAL_HI);
        foreach (corner[i]) send_cell(corner[i]);
        drain_results();
        write_config(0, 0, VAL_LO);
        foreach (corner[i]) send_cell(corner[8-i]);
        drain_results();
        write_config(1, 1, '0);
        foreach (corner[i]) send_cell(corner[i]);
    endtask

    // Lowering the size below the current column starts a new grid.
    task automatic test_shrink_past_grid();
        drain_results();
        write_config(5, 30000, pick_base());
        repeat (9) send_cell(pick_cell(1, '0));
        drain_results();
        write_config(4, $urandom_range(65535), pick_base());
        repeat (16) send_cell(pick_cell(1, '0));
    endtask

    // Largest grid, then a size above the maximum, which acts as the maximum.
    task automatic test_largest_grid();
        t_val base;
        logic [VAL_W-1:0] d;
        base = pick_base();
        drain_results();
        write_config(GRID_MAX, 6554, base);
        repeat (GRID_MAX + 4) send_cell(pick_cell(1, base));
        drain_results();
        d = 24'($urandom);
        d[GSIZE_W-1:0] = 9'($urandom_range(GRID_MAX + 1, 511));
        config_write(CFG_GRID_SIZE, d);
        i_cfg_valid <= 1'b0;
        repeat (4) send_cell(pick_cell(1, base));
        drain_results();
        d = 24'($urandom);
        d[GSIZE_W-1:0] = 9'd3;
        config_write(CFG_GRID_SIZE, d);
        i_cfg_valid <= 1'b0;
        repeat (9) send_cell(pick_cell(1, base));
    endtask

    // Whole grids of random size, gain, boundary and cell style.
    task automatic run_random_phase(input int item_goal);
        int   sent;
        int   n;
        int   gain;
        int   mode;
        int   count;
        t_val base;
        sent = 0;
        while (sent < item_goal) begin
            case ($urandom_range(9))
                0: n = $urandom_range(0, 2);
                1: n = $urandom_range(8, 11);
                default: n = $urandom_range(3, 7);
            endcase
            case ($urandom_range(7))
                0: gain = 0;
                1: gain = 65535;
                default: gain = $urandom_range(65535);
            endcase
            mode = $urandom_range(2);
            base = pick_base();
            drain_results();
            write_config(n, gain, pick_cell(mode, base));
            count = (n < 3) ? 9 : n * n;
            repeat (count) begin
                send_cell(pick_cell(mode, base));
                if ($urandom_range(63) == 0)
                    drain_results();
            end
            sent += count;
        end
    endtask

    initial begin
        row_pos     = 0;
        col_pos     = 0;
        prev_cell   = '0;
        grid_size_q = 9'd16;
        gain_q      = 16'd6554;
        bound_q     = ONE_VOLT;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_small_grid_extremes();
        test_shrink_past_grid();
        test_largest_grid();
        run_random_phase(10);
        sender_idle_pct = 68;
        recv_idle_pct   = 12;
        run_random_phase(10);
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        run_random_phase(10);

        drain_results();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
